@@ rtl/htd_pkg.sv @@
`default_nettype none

package htd_pkg;

    // Kind of an input request, carried on the slave-side tuser.
    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_DECODE = 1'b1
    } t_action;

    // Input field widths.
    localparam int IN_IDX_W = 9;
    localparam int IN_SYM_W = 8;

    // Output field width.
    localparam int OUT_SYM_W = 8;

    // Slave-side tdata layout, lowest bit first.
    localparam int NODE_INDEX_LSB  = 0;
    localparam int NODE_LEAF_LSB   = NODE_INDEX_LSB + IN_IDX_W;
    localparam int LEFT_CHILD_LSB  = NODE_LEAF_LSB + 1;
    localparam int RIGHT_CHILD_LSB = LEFT_CHILD_LSB + IN_IDX_W;
    localparam int LEAF_SYM_LSB    = RIGHT_CHILD_LSB + IN_IDX_W;
    localparam int CODE_BIT_LSB    = LEAF_SYM_LSB + IN_SYM_W;
    localparam int S_TDATA_W       = ((CODE_BIT_LSB + 1 + 7) / 8) * 8;

    // Master-side tdata is the symbol alone.
    localparam int M_TDATA_W = ((OUT_SYM_W + 7) / 8) * 8;

    // Result queue between the walk and the master side.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

@@ rtl/htd_ram.sv @@
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/huffman_tree_decoder_core.sv @@
`default_nettype none

// Huffman tree decoder core.
// The slave side takes one request per cycle. tuser selects the kind: a node write
// stores one entry of the code tree (root at index 0) and returns the walk to the
// root; a decode request carries one code bit and steps the walk by one node.
// A decode that lands on a leaf produces one symbol on the master side; all other
// requests produce nothing. Node and child indices are folded modulo NODE_COUNT.
// Throughput is one request per cycle while s_axis_tready is high, writes and
// decodes mixed freely. The node table read is registered; the entry read for one
// bit is used directly as the current node for the next bit, so the walk loop
// closes through the RAM output register each cycle. A symbol passes the pending
// step register and then the result queue before it is presented on the master side.
// Symbols pass through a four-entry result queue. s_axis_tready depends only on
// the queue fill and the one pending step, so a stalled receiver stops the
// slave side once the queue can no longer absorb a result; nothing is lost.
// Reset returns the walk to the root and empties the queue. The node table is not
// cleared; every node the walk reaches must have been written first.

module huffman_tree_decoder_core #(
    parameter int NODE_COUNT  = 512,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Fields from bit 0: node_index[8:0], node_is_leaf[9], left_child[18:10],
    // right_child[27:19], leaf_symbol[35:28], code_bit[36], zero fill [39:37].
    input  wire logic [htd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: action.
    input  wire logic                          s_axis_tuser,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: symbol[7:0].
    output logic      [htd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready
);

    import htd_pkg::*;

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int FOLD_W = (IDX_W > IN_IDX_W) ? IDX_W : IN_IDX_W;

    typedef struct packed {
        logic                   leaf;
        logic [IDX_W-1:0]       one_child;
        logic [IDX_W-1:0]       zero_child;
        logic [SYMBOL_BITS-1:0] sym;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Index modulo NODE_COUNT by restoring subtraction of shifted multiples.
    function automatic logic [IDX_W-1:0] fold_index(input logic [IN_IDX_W-1:0] v);
        logic [FOLD_W-1:0] r;
        r = FOLD_W'(v);
        for (int k = IN_IDX_W - 1; k >= 0; k--) begin
            if ((NODE_COUNT << k) < (1 << IN_IDX_W)) begin
                if (r >= FOLD_W'(NODE_COUNT << k)) begin
                    r = r - FOLD_W'(NODE_COUNT << k);
                end
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // Input request fields.
    t_action             in_action;
    logic [IN_IDX_W-1:0] in_node_index;
    logic                in_node_is_leaf;
    logic [IN_IDX_W-1:0] in_left_child;
    logic [IN_IDX_W-1:0] in_right_child;
    logic [IN_SYM_W-1:0] in_leaf_symbol;
    logic                in_code_bit;

    assign in_action       = t_action'(s_axis_tuser);
    assign in_node_index   = s_axis_tdata[NODE_INDEX_LSB +: IN_IDX_W];
    assign in_node_is_leaf = s_axis_tdata[NODE_LEAF_LSB];
    assign in_left_child   = s_axis_tdata[LEFT_CHILD_LSB +: IN_IDX_W];
    assign in_right_child  = s_axis_tdata[RIGHT_CHILD_LSB +: IN_IDX_W];
    assign in_leaf_symbol  = s_axis_tdata[LEAF_SYM_LSB +: IN_SYM_W];
    assign in_code_bit     = s_axis_tdata[CODE_BIT_LSB];

    // Walk state: a cached copy of the root entry, a flag saying whether the walk
    // stands on the root, and one pending step whose entry is on the RAM output.
    t_entry r_root;
    t_entry n_root;
    logic   r_at_root;
    logic   n_at_root;
    logic   r_s1_valid;
    logic   n_s1_valid;
    logic   r_s1_imm;
    logic   n_s1_imm;

    // Result queue.
    logic [OUT_SYM_W-1:0]   r_q [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wp;
    logic [QUEUE_PTR_W-1:0] n_wp;
    logic [QUEUE_PTR_W-1:0] r_rp;
    logic [QUEUE_PTR_W-1:0] n_rp;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic [QUEUE_CNT_W-1:0] n_cnt;

    logic                 in_acc;
    logic                 is_wr;
    logic                 is_dec;
    logic [IDX_W-1:0]     wr_addr;
    t_entry               wr_entry;
    logic [ENTRY_W-1:0]   ram_rdata_bits;
    t_entry               ram_rdata;
    logic                 s1_leaf;
    logic                 cur_is_root;
    t_entry               cur;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 push;
    logic [OUT_SYM_W-1:0] push_sym;
    logic                 pop;
    logic [QUEUE_CNT_W:0] room_need;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign is_wr  = in_acc && (in_action == ACT_WRITE);
    assign is_dec = in_acc && (in_action == ACT_DECODE);

    assign wr_addr             = fold_index(in_node_index);
    assign wr_entry.leaf       = in_node_is_leaf;
    assign wr_entry.one_child  = fold_index(in_left_child);
    assign wr_entry.zero_child = fold_index(in_right_child);
    assign wr_entry.sym        = SYMBOL_BITS'(in_leaf_symbol);

    htd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (is_wr),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata_bits)
    );

    assign ram_rdata = t_entry'(ram_rdata_bits);

    // Resolve the pending step: a leaf ends the code and puts the walk on the root.
    assign s1_leaf     = r_s1_imm || ram_rdata.leaf;
    assign cur_is_root = r_s1_valid ? s1_leaf : r_at_root;
    assign cur         = cur_is_root ? r_root : ram_rdata;

    // A leaf root emits its own symbol for every bit without a table read.
    assign rd_en   = is_dec && !cur.leaf;
    assign rd_addr = in_code_bit ? cur.one_child : cur.zero_child;

    assign push     = r_s1_valid && s1_leaf;
    assign push_sym = r_s1_imm ? OUT_SYM_W'(r_root.sym) : OUT_SYM_W'(ram_rdata.sym);
    assign pop      = m_axis_tvalid && m_axis_tready;

    // Room for the result already in flight plus one for the new request.
    assign room_need     = (QUEUE_CNT_W + 1)'(r_cnt) + (QUEUE_CNT_W + 1)'(r_s1_valid);
    assign s_axis_tready = room_need < (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);

    assign m_axis_tvalid = r_cnt != '0;
    assign m_axis_tdata  = M_TDATA_W'(r_q[r_rp]);

    always_comb begin
        n_root     = r_root;
        n_at_root  = r_at_root;
        n_s1_valid = is_dec;
        n_s1_imm   = is_dec && cur.leaf;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_cnt      = r_cnt;
        if (r_s1_valid) begin
            n_at_root = s1_leaf;
        end
        if (is_wr) begin
            n_at_root = 1'b1;
            if (wr_addr == '0) begin
                n_root = wr_entry;
            end
        end
        if (push) begin
            n_wp = r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root     <= '0;
            r_at_root  <= 1'b1;
            r_s1_valid <= 1'b0;
            r_s1_imm   <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            r_root     <= n_root;
            r_at_root  <= n_at_root;
            r_s1_valid <= n_s1_valid;
            r_s1_imm   <= n_s1_imm;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= push_sym;
        end
    end

    a_queue_no_overflow : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH)))
    ) else $error("result queue overflow");

    a_queue_bound : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_CNT_W'(QUEUE_DEPTH)
    ) else $error("result queue count out of range");

    a_write_to_root : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        is_wr |=> (r_at_root && !r_s1_valid)
    ) else $error("node write did not return the walk to the root");

    a_imm_in_step : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_s1_imm |-> r_s1_valid
    ) else $error("root leaf step without a pending step");

    a_read_only_on_decode : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_imm |-> $past(rd_en)
    ) else $error("pending step without a table read");

endmodule

`default_nettype wire

@@ sim/huffman_tree_decoder_checker.sv @@
`default_nettype none

module huffman_tree_decoder_checker #(
    parameter int NODE_COUNT = 512
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Fields from bit 0: node_index, node_is_leaf, left_child, right_child,
    // leaf_symbol, code_bit, zero fill.
    input  wire logic [htd_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // Fields from bit 0: action.
    input  wire logic                          i_s_axis_tuser,
    input  wire logic                          i_s_axis_tvalid,
    input  wire logic                          i_s_axis_tready,
    // Fields from bit 0: symbol.
    input  wire logic [htd_pkg::M_TDATA_W-1:0] i_m_axis_tdata,
    input  wire logic                          i_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_symbols,
    output int                                 o_requests
);

    import htd_pkg::*;

    typedef struct packed {
        logic                is_leaf;
        logic [IN_IDX_W-1:0] one_child;
        logic [IN_IDX_W-1:0] zero_child;
        logic [IN_SYM_W-1:0] sym;
    } t_tree_node;

    t_tree_node           tree_nodes [NODE_COUNT];
    logic [IN_IDX_W-1:0]  walk_node;
    logic [IN_IDX_W-1:0]  next_node;
    logic [OUT_SYM_W-1:0] symbols_due [$];
    logic [OUT_SYM_W-1:0] due_symbol;
    t_action              req_action;
    int                   fail_total = 0;
    int                   symbol_total = 0;
    int                   request_total = 0;

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            walk_node = '0;
            symbols_due.delete();
        end else begin
            // Outputs pass the pending step and the result queue after the completing bit,
            // so a request taken at this edge never affects the symbol being compared here.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (symbols_due.size() == 0) begin
                    report_mismatch($sformatf("symbol %02h with none expected",
                                              i_m_axis_tdata[OUT_SYM_W-1:0]));
                end else begin
                    due_symbol = symbols_due.pop_front();
                    symbol_total++;
                    if (i_m_axis_tdata[OUT_SYM_W-1:0] !== due_symbol) begin
                        report_mismatch($sformatf("symbol %02h, expected %02h",
                                                  i_m_axis_tdata[OUT_SYM_W-1:0],
                                                  due_symbol));
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                request_total++;
                req_action = t_action'(i_s_axis_tuser);
                if (req_action == ACT_WRITE) begin
                    next_node = IN_IDX_W'(i_s_axis_tdata[NODE_INDEX_LSB +: IN_IDX_W]
                                          % NODE_COUNT);
                    tree_nodes[next_node].is_leaf    = i_s_axis_tdata[NODE_LEAF_LSB];
                    tree_nodes[next_node].one_child  =
                        IN_IDX_W'(i_s_axis_tdata[LEFT_CHILD_LSB +: IN_IDX_W] % NODE_COUNT);
                    tree_nodes[next_node].zero_child =
                        IN_IDX_W'(i_s_axis_tdata[RIGHT_CHILD_LSB +: IN_IDX_W] % NODE_COUNT);
                    tree_nodes[next_node].sym        = i_s_axis_tdata[LEAF_SYM_LSB +: IN_SYM_W];
                    walk_node = '0;
                end else begin
                    // A leaf at the current position (only the root can be one)
                    // emits without a step; otherwise take one step first.
                    next_node = walk_node;
                    if (!tree_nodes[next_node].is_leaf) begin
                        next_node = i_s_axis_tdata[CODE_BIT_LSB] ?
                                    tree_nodes[next_node].one_child :
                                    tree_nodes[next_node].zero_child;
                    end
                    if (tree_nodes[next_node].is_leaf) begin
                        symbols_due = {symbols_due,
                                       OUT_SYM_W'(tree_nodes[next_node].sym)};
                        walk_node = '0;
                    end else begin
                        walk_node = next_node;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= symbols_due.size();
        o_symbols    <= symbol_total;
        o_requests   <= request_total;
    end

endmodule

`default_nettype wire

@@ sim/huffman_tree_decoder_core_test.sv @@
`default_nettype none

module huffman_tree_decoder_core_test;

    import htd_pkg::*;

    localparam int NODE_COUNT     = 512;
    localparam int ITEM_TARGET    = 1150;
    localparam int MAX_GAP        = 12;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    // Fields from bit 0: node_index, node_is_leaf, left_child, right_child,
    // leaf_symbol, code_bit, zero fill.
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // Fields from bit 0: action.
    logic                 s_axis_tuser  = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0: symbol.
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    int  fail_count;
    int  pending_symbols;
    int  symbols_checked;
    int  requests_seen;
    int  requests_sent  = 0;
    int  trees_built    = 0;
    int  quiet_cycles   = 0;
    bit  sender_gaps    = 1'b1;
    bit  receiver_stall = 1'b1;
    bit  node_written [NODE_COUNT];
    bit  slot_taken [NODE_COUNT];

    huffman_tree_decoder_core #(
        .NODE_COUNT  (NODE_COUNT),
        .SYMBOL_BITS (8)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    huffman_tree_decoder_checker #(
        .NODE_COUNT (NODE_COUNT)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_fail_count    (fail_count),
        .o_pending       (pending_symbols),
        .o_symbols       (symbols_checked),
        .o_requests      (requests_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Called at a rising edge; returns at the edge where the request is taken,
    // leaving tvalid high so back-to-back requests need no extra assignment.
    task automatic push_request(input t_action act, input logic [8:0] idx,
                                input logic leaf, input logic [8:0] one_c,
                                input logic [8:0] zero_c, input logic [7:0] sym,
                                input logic code);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[NODE_INDEX_LSB +: IN_IDX_W]  = idx;
        word[NODE_LEAF_LSB]               = leaf;
        word[LEFT_CHILD_LSB +: IN_IDX_W]  = one_c;
        word[RIGHT_CHILD_LSB +: IN_IDX_W] = zero_c;
        word[LEAF_SYM_LSB +: IN_SYM_W]    = sym;
        word[CODE_BIT_LSB]                = code;
        gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= word;
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    // Internal nodes only ever point at entries already written or at themselves, so no
    // walk can reach an entry that was never written.
    task automatic write_node(input logic [8:0] idx, input logic leaf,
                              input logic [8:0] one_c, input logic [8:0] zero_c,
                              input logic [7:0] sym);
        node_written[idx] = 1'b1;
        push_request(ACT_WRITE, idx, leaf, one_c, zero_c, sym, 1'b0);
    endtask

    task automatic decode_bit(input logic code);
        push_request(ACT_DECODE, 9'($urandom_range(0, 511)), 1'($urandom),
                     9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                     8'($urandom_range(0, 255)), code);
    endtask

    function automatic int pick_free_slot();
        int idx;
        do idx = $urandom_range(1, NODE_COUNT - 1); while (slot_taken[idx]);
        slot_taken[idx] = 1'b1;
        return idx;
    endfunction

    // A single leaf goes on the root; otherwise leaves go at fresh random slots, then
    // random pairs merge bottom-up until the last merge lands on the root.
    task automatic build_tree(input int leaf_total);
        int subtrees [$];
        int pick;
        int left_idx;
        int right_idx;
        int idx;
        int k;
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        slot_taken[0] = 1'b1;
        trees_built++;
        if (leaf_total == 1) begin
            write_node(9'd0, 1'b1, 9'($urandom_range(0, 511)),
                       9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        end else begin
            for (k = 0; k < leaf_total; k++) begin
                idx = pick_free_slot();
                write_node(9'(idx), 1'b1, 9'($urandom_range(0, 511)),
                           9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
                subtrees = {subtrees, idx};
            end
            while (subtrees.size() > 1) begin
                pick = $urandom_range(0, subtrees.size() - 1);
                left_idx = subtrees[pick];
                subtrees.delete(pick);
                pick = $urandom_range(0, subtrees.size() - 1);
                right_idx = subtrees[pick];
                subtrees.delete(pick);
                idx = (subtrees.size() == 0) ? 0 : pick_free_slot();
                write_node(9'(idx), 1'b0, 9'(left_idx), 9'(right_idx),
                           8'($urandom_range(0, 255)));
                subtrees = {subtrees, idx};
            end
        end
    endtask

    // Random write anywhere, which also breaks off any code in progress.
    task automatic stray_write();
        int one_c;
        int zero_c;
        do one_c = $urandom_range(0, NODE_COUNT - 1); while (!node_written[one_c]);
        do zero_c = $urandom_range(0, NODE_COUNT - 1); while (!node_written[zero_c]);
        write_node(9'($urandom_range(0, 511)), 1'($urandom), 9'(one_c), 9'(zero_c),
                   8'($urandom_range(0, 255)));
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                break;
            end
        end
        forever begin
            int stall;
            stall = receiver_stall ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Timeout: no request or symbol moved for %0d cycles",
                         WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int bit_total;
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Root that is itself a leaf: every bit emits the root symbol.
        write_node(9'd0, 1'b1, 9'd511, 9'd0, 8'hFF);
        decode_bit(1'b0);
        decode_bit(1'b1);
        // One-bit codes to the extreme slots and symbols.
        write_node(9'd511, 1'b1, 9'd0, 9'd511, 8'h00);
        write_node(9'd1, 1'b1, 9'd511, 9'd511, 8'hA5);
        write_node(9'd0, 1'b0, 9'd511, 9'd1, 8'h5A);
        decode_bit(1'b1);
        decode_bit(1'b0);
        // Deeper code with a node that points at itself on bit 1.
        write_node(9'd2, 1'b0, 9'd2, 9'd1, 8'hC3);
        write_node(9'd0, 1'b0, 9'd2, 9'd511, 8'h3C);
        decode_bit(1'b1);
        decode_bit(1'b1);
        decode_bit(1'b0);
        // A write in the middle of a code sends the walk back to the root.
        decode_bit(1'b1);
        write_node(9'd3, 1'b1, 9'd0, 9'd0, 8'h81);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b0);

        while (requests_sent < ITEM_TARGET) begin
            sender_gaps    = ($urandom_range(0, 3) != 0);
            receiver_stall = ($urandom_range(0, 3) != 0);
            build_tree(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10));
            bit_total = $urandom_range(10, 60);
            for (k = 0; k < bit_total; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    stray_write();
                end
                decode_bit(1'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending_symbols != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests over %0d code trees plus directed cases;",
                 requests_seen, trees_built);
        $display("checked %0d decoded symbols with random gaps and stalls.",
                 symbols_checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
